### sv/mbps_pkg.sv
// shared widths, register indexes and defaults for the masked byte pattern search
package mbps_pkg;

  localparam int BYTE_W         = 8;
  localparam int PATTERN_W      = 64;
  localparam int CARE_W         = 8;
  localparam int LEN_REG_W      = 4;
  localparam int START_W        = 32;
  localparam int MATCH_OFFSET_W = 32;
  localparam int CFG_INDEX_W    = 8;
  localparam int CFG_DATA_W     = 64;

  localparam int DEF_MAX_PATTERN = 8;
  localparam int DEF_OFFSET_BITS = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_BYTES  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_BYTE_CARE      = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_START_OFFSET   = CFG_INDEX_W'(3);

  // register reset values
  localparam logic [PATTERN_W-1:0] PATTERN_RESET = '0;
  localparam logic [CARE_W-1:0]    CARE_RESET    = 8'hFF;
  localparam logic [LEN_REG_W-1:0] LENGTH_RESET  = LEN_REG_W'(1);
  localparam logic [START_W-1:0]   START_RESET   = '0;

endpackage

### sv/mbps_window_match.sv
// masked compare of the byte window against the configured pattern
module mbps_window_match #(
  parameter int MAX_PATTERN = mbps_pkg::DEF_MAX_PATTERN,
  parameter int LW          = $clog2(MAX_PATTERN + 1)
) (
  input  logic [MAX_PATTERN*mbps_pkg::BYTE_W-1:0] window,  // newest byte lowest
  input  logic [mbps_pkg::PATTERN_W-1:0]          pattern,
  input  logic [mbps_pkg::CARE_W-1:0]             care,
  input  logic [LW-1:0]                           len,
  output logic                                    hit
);
  import mbps_pkg::*;

  logic [BYTE_W-1:0] got;

  // pattern byte i lines up with window byte len-1-i
  always_comb begin
    hit = 1'b1;
    got = '0;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      got = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
        if (i + j + 1 == int'(len)) begin
          got = got | window[j*BYTE_W +: BYTE_W];
        end
      end
      if (i < int'(len) && care[i] && got != pattern[i*BYTE_W +: BYTE_W]) begin
        hit = 1'b0;
      end
    end
  end

endmodule

### sv/masked_byte_pattern_search.sv
// top level of the masked byte pattern search
//
// a data block streams in on the s_ side, one byte per word, with s_tlast on
// its final byte. the block keeps the most recent MAX_PATTERN bytes and checks
// them against a pattern of up to eight bytes, each byte either compared
// exactly or taken as a wildcard. per block there is exactly one result word
// on the m_ side: found with the offset of the first match at or after
// start_offset, sent as soon as the match completes, or not found (offset 0)
// sent with the final byte. a match must lie wholly inside the block.
// configuration goes in over the cfg channel (index, 64-bit data), always
// ready; write it only while no block is in flight.
// throughput is one byte per cycle unless a held result stalls the input; the
// window compare, offset check and counter update all sit between the block
// state and the result register, so the result word shows on m_tvalid in the
// cycle after the byte that completes a match (or the final byte) is accepted.
// reset clears the window, byte count and report flag and returns the
// registers to pattern 0, care 0xFF, length 1, start offset 0.
// when the receiver stalls, the result word holds and s_tready drops only
// while a held result still waits and m_tready is low.
module masked_byte_pattern_search #(
  parameter int MAX_PATTERN = mbps_pkg::DEF_MAX_PATTERN,
  parameter int OFFSET_BITS = mbps_pkg::DEF_OFFSET_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
  // byte input
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [mbps_pkg::BYTE_W-1:0]         s_tdata,   // data_byte
  input  logic                                s_tlast,   // last_byte
  // result output
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [mbps_pkg::MATCH_OFFSET_W-1:0] m_tdata,   // match_offset
  output logic                                m_tuser    // found
);
  import mbps_pkg::*;

  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int WW = MAX_PATTERN * BYTE_W;
  // wide enough for both the byte count and the start offset register
  localparam int CW = (OFFSET_BITS > START_W) ? OFFSET_BITS : START_W;
  localparam logic [OFFSET_BITS-1:0] CNT_FULL = '1;

  // configuration registers
  logic [PATTERN_W-1:0] pattern_bytes;
  logic [CARE_W-1:0]    byte_care;
  logic [LEN_REG_W-1:0] pattern_length;
  logic [START_W-1:0]   start_offset;

  // per-block state
  logic [WW-1:0]          byte_window;   // newest byte in the low bits
  logic [WW-1:0]          window_next;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   match_reported;

  // result register
  logic                      out_found;
  logic [MATCH_OFFSET_W-1:0] out_offset;

  logic [LW-1:0] eff_len;
  logic [CW:0]   count_plus;
  logic [CW:0]   len_ext;
  logic [CW:0]   match_start;
  logic          window_hit;
  logic          long_enough;
  logic          start_ok;
  logic          not_full;
  logic          hit;
  logic          reported_new;
  logic          emit;
  logic          accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes  <= PATTERN_RESET;
      byte_care      <= CARE_RESET;
      pattern_length <= LENGTH_RESET;
      start_offset   <= START_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PATTERN_BYTES:  pattern_bytes  <= cfg_data[PATTERN_W-1:0];
        REG_BYTE_CARE:      byte_care      <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_REG_W-1:0];
        REG_START_OFFSET:   start_offset   <= cfg_data[START_W-1:0];
        default: ;
      endcase
    end
  end

  // length zero acts as one, anything past the window saturates
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LW'(1);
    end else if (pattern_length > LEN_REG_W'(MAX_PATTERN)) begin
      eff_len = LW'(MAX_PATTERN);
    end else begin
      eff_len = LW'(pattern_length);
    end
  end

  // shift the arriving byte into the window
  always_comb begin
    window_next = byte_window << BYTE_W;
    window_next[BYTE_W-1:0] = s_tdata;
  end

  mbps_window_match #(
    .MAX_PATTERN (MAX_PATTERN),
    .LW          (LW)
  ) u_match (
    .window  (window_next),
    .pattern (pattern_bytes),
    .care    (byte_care),
    .len     (eff_len),
    .hit     (window_hit)
  );

  // the arriving byte sits at offset bytes_seen; the match would start
  // len-1 bytes earlier
  assign count_plus   = (CW + 1)'(bytes_seen) + (CW + 1)'(1);
  assign len_ext      = (CW + 1)'(eff_len);
  assign match_start  = count_plus - len_ext;
  assign long_enough  = count_plus >= len_ext;
  assign start_ok     = match_start >= (CW + 1)'(start_offset);
  assign not_full     = bytes_seen != CNT_FULL;

  assign hit          = !match_reported && not_full && long_enough && start_ok
                        && window_hit;
  assign reported_new = match_reported | hit;
  // a block that ends without a match reports not found on its final byte
  assign emit         = hit | (s_tlast & !reported_new);

  assign s_tready = !m_tvalid | m_tready;
  assign accept   = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_window    <= '0;
      bytes_seen     <= '0;
      match_reported <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        byte_window    <= '0;
        bytes_seen     <= '0;
        match_reported <= 1'b0;
      end else begin
        byte_window    <= window_next;
        match_reported <= reported_new;
        if (not_full) begin
          bytes_seen <= bytes_seen + OFFSET_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= emit;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_found  <= hit;
      out_offset <= hit ? match_start[MATCH_OFFSET_W-1:0] : '0;
    end
  end

  assign m_tuser = out_found;
  assign m_tdata = out_offset;

endmodule

### sv/mbps_checker.sv
// port checker for the masked byte pattern search, bound to the top level
module mbps_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [mbps_pkg::MATCH_OFFSET_W-1:0] m_tdata,
  input logic                                m_tuser
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // not found always carries offset zero
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("not found word with nonzero offset");

  // no result word right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word right after reset");

  // input is never blocked while the result register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty result register");

  // a result word only follows an accepted byte
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result word without an accepted byte");

endmodule

bind masked_byte_pattern_search mbps_checker u_checker (.*);

### tb/masked_byte_pattern_search_test.sv
`timescale 1ns / 100ps
// testbench for the masked byte pattern search: directed blocks, back pressure, random blocks
module masked_byte_pattern_search_test;
  import mbps_pkg::*;

  localparam int LEN_MAX        = DEF_MAX_PATTERN;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving on any channel
  localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
  localparam int SETTLE_CYCLES  = 3;     // leave some slack after the last result word

  // one result word: found flag and the offset of the first matching byte
  typedef struct {
    logic                      found;
    logic [MATCH_OFFSET_W-1:0] offset;
  } search_result_t;

  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]     cfg_data  = '0;
  logic                      s_tvalid  = 1'b0;
  logic                      s_tready;
  logic [BYTE_W-1:0]         s_tdata   = '0;   // data_byte
  logic                      s_tlast   = 1'b0; // last_byte
  logic                      m_tvalid;
  logic                      m_tready  = 1'b0;
  logic [MATCH_OFFSET_W-1:0] m_tdata;          // match_offset
  logic                      m_tuser;          // found

  masked_byte_pattern_search dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // predictor copy of the registers
  logic [PATTERN_W-1:0] pattern_q;
  logic [CARE_W-1:0]    care_q;
  logic [LEN_REG_W-1:0] length_q;
  logic [START_W-1:0]   start_q;

  // predictor copy of the per-block state
  logic [BYTE_W-1:0]          window_q [LEN_MAX];  // newest byte at index 0
  logic [DEF_OFFSET_BITS-1:0] bytes_seen;
  logic                       reported;

  search_result_t pending_results[$];

  // stimulus shaping; the receiver process reads recv_idle_pct and hold_seq
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_seq      = 0;

  // bookkeeping
  int mismatches    = 0;
  int bytes_sent    = 0;
  int blocks_sent   = 0;
  int found_words   = 0;
  int absent_words  = 0;
  int input_stalls  = 0;
  int quiet_cycles  = 0;

  // scratch block for the random traffic
  logic [BYTE_W-1:0] block_buf [64];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_block();
    int i;
    for (i = 0; i < LEN_MAX; i++) window_q[i] = '0;
    bytes_seen = '0;
    reported   = 1'b0;
  endfunction

  // length zero counts as one, anything past the window saturates
  function automatic int unsigned active_length();
    if (length_q == '0) return 1;
    if (length_q > LEN_REG_W'(LEN_MAX)) return LEN_MAX;
    return 32'(length_q);
  endfunction

  function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_PATTERN_BYTES:  pattern_q = value[PATTERN_W-1:0];
      REG_BYTE_CARE:      care_q    = value[CARE_W-1:0];
      REG_PATTERN_LENGTH: length_q  = value[LEN_REG_W-1:0];
      REG_START_OFFSET:   start_q   = value[START_W-1:0];
      default: ;
    endcase
  endfunction

  // shift in one byte and queue the result word it causes, if any
  function automatic void predict_search(input logic [BYTE_W-1:0] b, input logic last);
    int unsigned plen;
    int i;
    logic [DEF_OFFSET_BITS-1:0] pos_now;
    logic [DEF_OFFSET_BITS-1:0] first;
    logic hit;
    search_result_t res;
    plen    = active_length();
    pos_now = bytes_seen;
    for (i = LEN_MAX - 1; i > 0; i--) window_q[i] = window_q[i-1];
    window_q[0] = b;
    // the whole pattern has to sit inside the block, and a saturated count never matches
    if (!reported && pos_now != '1 &&
        ({1'b0, pos_now} + 33'd1 >= 33'(plen))) begin
      first = pos_now + 32'd1 - 32'(plen);
      hit   = (first >= start_q);
      for (i = 0; i < int'(plen); i++)
        if (care_q[i] && window_q[int'(plen) - 1 - i] != pattern_q[8*i +: 8]) hit = 1'b0;
      if (hit) begin
        reported   = 1'b1;
        res.found  = 1'b1;
        res.offset = first;
        pending_results.push_back(res);
      end
    end
    if (pos_now != '1) bytes_seen = pos_now + DEF_OFFSET_BITS'(1);
    if (last) begin
      // not found goes out with the final byte only when nothing was reported
      if (!reported) begin
        res.found  = 1'b0;
        res.offset = '0;
        pending_results.push_back(res);
      end
      clear_block();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // receiver: random stalls plus a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : drive_ready
    int hold_left;
    int hold_seen;
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker, values sampled as they stood before the edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_results
    search_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (m_tuser) found_words++;
      else absent_words++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: found %0b offset %0d", m_tuser, m_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, m_tuser);
          mismatches++;
        end
        if (m_tdata !== want.offset) begin
          $error("match_offset: expected %0d, got %0d", want.offset, m_tdata);
          mismatches++;
        end
      end
    end
    if (!rst && s_tvalid && !s_tready) input_stalls++;
  end

  // watchdog: any word moving on any channel keeps the run alive
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, pending_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // offer one byte, idling first at random; tvalid stays high after acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_search(b, last);
    bytes_sent++;
    if (last) blocks_sent++;
  endtask

  // stop offering and wait until every expected word is back and the block settled
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // all four registers, written only once the block has gone idle
  task automatic set_registers(input logic [CFG_DATA_W-1:0] pattern,
                               input logic [CFG_DATA_W-1:0] care,
                               input logic [CFG_DATA_W-1:0] len,
                               input logic [CFG_DATA_W-1:0] start);
    wait_idle();
    write_register(REG_PATTERN_BYTES, pattern);
    write_register(REG_BYTE_CARE, care);
    write_register(REG_PATTERN_LENGTH, len);
    write_register(REG_START_OFFSET, start);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // registers straight out of reset: pattern 0x00, exact, length 1, start 0
  task automatic test_reset_values();
    send_byte(8'h00, 1'b1);  // match on the final byte of a one-byte block
    send_byte(8'hFF, 1'b1);  // no match, not found
  endtask

  // DE AD ?? EF with a start offset that skips the first copy
  task automatic test_wildcard_and_start();
    set_registers(64'h0000_0000_EF00_ADDE, 64'h0B, 64'd4, 64'd2);
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'h77, 1'b0);  // wildcard position
    send_byte(8'hEF, 1'b0);  // first copy at offset 0, below the start offset
    send_byte(8'hDE, 1'b0);
    send_byte(8'hAD, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hEF, 1'b1);  // second copy at offset 4 completes on the final byte
  endtask

  // three wildcards then 5A: the zeroed window must not let a short block match,
  // and a second match in the same block stays silent
  task automatic test_short_block_and_repeat();
    set_registers(64'h0000_0000_5A00_0000, 64'h08, 64'd4, 64'd0);
    send_byte(8'h5A, 1'b1);  // too short: not found
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h5A, 1'b0);  // found at 0
    send_byte(8'h5A, 1'b1);  // repeat match, final byte gives nothing
  endtask

  // length 0 acts as 1, length 15 acts as 8, and the top start offset never matches
  task automatic test_length_limits();
    logic [PATTERN_W-1:0] pat;
    int i;
    pat = 64'h0011_2233_4455_66FF;
    set_registers(64'hFF, 64'hFF, 64'd0, 64'd1);
    send_byte(8'hFF, 1'b0);  // below the start offset
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);  // found at 2
    set_registers(pat, 64'hFF, 64'hF, 64'd0);
    for (i = 0; i < LEN_MAX; i++) send_byte(pat[8*i +: 8], i == LEN_MAX - 1);
    set_registers(pat, 64'h00, 64'd1, 64'hFFFF_FFFF);
    send_byte(8'hFF, 1'b1);  // everything is a wildcard but the start is out of reach
  endtask

  // receiver holds off while one-byte blocks keep coming, so the held result
  // backs up into s_tready; then the sender waits for every result
  task automatic test_result_backpressure();
    int i;
    set_registers({$urandom, $urandom}, 64'h00, 64'd1, 64'd0);
    send_idle_pct = 0;
    hold_seq      = hold_seq + 1;
    for (i = 0; i < 24; i++) send_byte(8'($urandom), 1'b1);
    wait_idle();
  endtask

  // random registers, biased toward useful settings, junk above each field
  task automatic random_registers();
    logic [CFG_DATA_W-1:0] care;
    logic [CFG_DATA_W-1:0] len;
    logic [CFG_DATA_W-1:0] start;
    care  = {$urandom, $urandom};
    len   = {$urandom, $urandom};
    start = {$urandom, $urandom};
    case ($urandom_range(3))
      0: care[CARE_W-1:0] = 8'hFF;
      1: care[CARE_W-1:0] = 8'h00;
      default: ;
    endcase
    if ($urandom_range(9) < 8) len[LEN_REG_W-1:0] = LEN_REG_W'($urandom_range(1, LEN_MAX));
    case ($urandom_range(19))
      0:                start[START_W-1:0] = '1;
      1:                ;  // anything at all
      2, 3, 4, 5, 6, 7: start[START_W-1:0] = START_W'($urandom_range(1, 12));
      default:          start[START_W-1:0] = '0;
    endcase
    set_registers({$urandom, $urandom}, care, len, start);
  endtask

  // one block of random bytes, usually with the pattern planted, sometimes damaged
  task automatic random_block();
    int blen;
    int plen;
    int pos;
    int i;
    int copies;
    plen = active_length();
    blen = ($urandom_range(9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 16);
    for (i = 0; i < blen; i++) block_buf[i] = 8'($urandom);
    copies = (blen >= plen && $urandom_range(99) < 75) ? $urandom_range(1, 2) : 0;
    repeat (copies) begin
      pos = $urandom_range(0, blen - plen);
      for (i = 0; i < plen; i++)
        if (care_q[i]) block_buf[pos + i] = pattern_q[8*i +: 8];
      if ($urandom_range(99) < 20) begin
        i = $urandom_range(0, plen - 1);
        block_buf[pos + i] = block_buf[pos + i] ^ 8'($urandom_range(1, 255));
      end
    end
    for (i = 0; i < blen; i++) send_byte(block_buf[i], i == blen - 1);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_bytes);
    int target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target        = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      random_registers();
      repeat ($urandom_range(2, 5)) random_block();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    pattern_q = PATTERN_RESET;
    care_q    = CARE_RESET;
    length_q  = LENGTH_RESET;
    start_q   = START_RESET;
    clear_block();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 25;
    recv_idle_pct = 59;
    test_reset_values();
    test_wildcard_and_start();
    test_short_block_and_repeat();
    test_length_limits();
    test_result_backpressure();

    test_random_traffic(25, 59, 250);
    test_random_traffic(59, 25, 250);
    test_random_traffic(0, 0, 250);

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end
    $display("covered %0d bytes in %0d blocks: %0d found, %0d not found, %0d input stall cycles",
             bytes_sent, blocks_sent, found_words, absent_words, input_stalls);
    $display("%0d field mismatches", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
sv/mbps_pkg.sv
sv/mbps_window_match.sv
sv/masked_byte_pattern_search.sv
sv/mbps_checker.sv
tb/masked_byte_pattern_search_test.sv
